// ----- hw/rtl/sdr_pkg.sv -----
package sdr_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_TICK_BITS    = 32;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_W      = 16;
  localparam int CFG_N      = 8;
  localparam int CFG_IDX_W  = 3;

  localparam int POS_W  = 24;
  localparam int VEL_W  = 16;
  localparam int QUAT_W = 16;
  localparam int HEAD_W = 17;
  localparam int MOP_W  = 26;
  localparam int PROD_W = 52;
  localparam int ACC_W  = 54;
  localparam int CX_W   = 38;
  localparam int CU_W   = 34;

  localparam logic [1:0] CMD_ODOM = 2'd0;
  localparam logic [1:0] CMD_GOAL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIMB     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd7;

  localparam logic [CFG_N-1:0][CFG_W-1:0] CFG_RESET = {
    16'd20, 16'd300, 16'd1500, 16'd80, 16'd500, 16'd1200, 16'd25, 16'd120
  };

  localparam logic signed [CU_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;
  localparam logic signed [CX_W-1:0] ONE_Q28         = 38'sd268435456;
  localparam logic signed [HEAD_W-1:0] ONE_Q14       = 17'sd16384;

  localparam logic [3:0] SEL_QYY = 4'd0;
  localparam logic [3:0] SEL_QZZ = 4'd1;
  localparam logic [3:0] SEL_QWZ = 4'd2;
  localparam logic [3:0] SEL_QXY = 4'd3;
  localparam logic [3:0] SEL_VXX = 4'd4;
  localparam logic [3:0] SEL_VYY = 4'd5;
  localparam logic [3:0] SEL_VZZ = 4'd6;
  localparam logic [3:0] SEL_THR = 4'd7;
  localparam logic [3:0] SEL_DXX = 4'd8;
  localparam logic [3:0] SEL_DYY = 4'd9;
  localparam logic [3:0] SEL_DZZ = 4'd10;
  localparam logic [3:0] SEL_RR  = 4'd11;
  localparam logic [3:0] SEL_BDC = 4'd12;
  localparam logic [3:0] SEL_BDS = 4'd13;

  typedef enum logic [3:0] {
    OP_NONE, OP_MUL, OP_MAC, OP_SAVE_A, OP_CINIT, OP_CSTEP, OP_CFIN, OP_GOAL,
    OP_TICK, OP_SLOW, OP_REACH, OP_DECIDE, OP_TX, OP_TY, OP_STUCK, OP_EMIT
  } sdr_op_e;

  typedef struct packed {
    sdr_op_e    op;
    logic [3:0] sel;
    logic       clr;
    logic       load;
  } sdr_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       odom_seen;
    logic       cordic_last;
    logic       stuck_now;
    logic       out_free;
  } sdr_stat_t;

endpackage

// ----- hw/rtl/stuck_detect_recovery_goal_core.sv -----
// Stuck detector with a backward-and-up recovery goal. Odometry words store position,
// velocity and a heading cosine/sine pair computed by an iterative CORDIC; goal words arm
// tracking; tick words drop a reached or stale goal, time low speed, and once odometry has
// been seen emit one result word each, carrying a saturated recovery target when stuck.
// One word is processed at a time on a single shared 26x26 multiplier, and a new word is
// accepted only once the last is done, after any wait for the result register to drain.
module stuck_detect_recovery_goal_core import sdr_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int TICK_BITS    = DEF_TICK_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, quat_x, quat_y, quat_z, quat_w
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // target_x, target_y, target_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // stuck_flag, target_valid
  output logic [1:0]            m_axis_tuser_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  sdr_cmd_t  cmd;
  sdr_stat_t stat;

  sdr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sdr_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .TICK_BITS    (TICK_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

endmodule

// ----- hw/rtl/sdr_ctrl.sv -----
module sdr_ctrl import sdr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  input  sdr_stat_t stat_i,
  output sdr_cmd_t  cmd_o
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DISPATCH = 5'd1;
  localparam logic [4:0] ST_MUL      = 5'd2;
  localparam logic [4:0] ST_MAC      = 5'd3;
  localparam logic [4:0] ST_SAVE_A   = 5'd4;
  localparam logic [4:0] ST_CINIT    = 5'd5;
  localparam logic [4:0] ST_CSTEP    = 5'd6;
  localparam logic [4:0] ST_CFIN     = 5'd7;
  localparam logic [4:0] ST_GOAL     = 5'd8;
  localparam logic [4:0] ST_TICK     = 5'd9;
  localparam logic [4:0] ST_SLOW     = 5'd10;
  localparam logic [4:0] ST_REACH    = 5'd11;
  localparam logic [4:0] ST_DECIDE   = 5'd12;
  localparam logic [4:0] ST_TX       = 5'd13;
  localparam logic [4:0] ST_TY       = 5'd14;
  localparam logic [4:0] ST_STUCK    = 5'd15;
  localparam logic [4:0] ST_EMIT     = 5'd16;

  logic [4:0] state_q, state_d;
  logic [3:0] sel_q, sel_d;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = sel_q;
    cmd_o.clr  = 1'b0;
    cmd_o.load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority case (stat_i.command)
          CMD_ODOM: begin
            sel_d   = SEL_QYY;
            state_d = ST_MUL;
          end
          CMD_GOAL: state_d = ST_GOAL;
          CMD_TICK: state_d = ST_TICK;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        priority case (sel_q)
          SEL_THR: state_d = ST_SLOW;
          SEL_RR:  state_d = ST_REACH;
          SEL_BDC: state_d = ST_TX;
          SEL_BDS: state_d = ST_TY;
          default: state_d = ST_MAC;
        endcase
      end
      ST_MAC: begin
        cmd_o.op  = OP_MAC;
        cmd_o.clr = (sel_q == SEL_QYY) || (sel_q == SEL_QWZ) ||
                    (sel_q == SEL_VXX) || (sel_q == SEL_DXX);
        priority case (sel_q)
          SEL_QZZ: state_d = ST_SAVE_A;
          SEL_QXY: state_d = ST_CINIT;
          default: begin
            sel_d   = sel_q + 4'd1;
            state_d = ST_MUL;
          end
        endcase
      end
      ST_SAVE_A: begin
        cmd_o.op = OP_SAVE_A;
        sel_d    = SEL_QWZ;
        state_d  = ST_MUL;
      end
      ST_CINIT: begin
        cmd_o.op = OP_CINIT;
        state_d  = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd_o.op = OP_CSTEP;
        if (stat_i.cordic_last) begin
          state_d = ST_CFIN;
        end
      end
      ST_CFIN: begin
        cmd_o.op = OP_CFIN;
        state_d  = ST_IDLE;
      end
      ST_GOAL: begin
        cmd_o.op = OP_GOAL;
        state_d  = ST_IDLE;
      end
      ST_TICK: begin
        cmd_o.op = OP_TICK;
        if (stat_i.odom_seen) begin
          sel_d   = SEL_VXX;
          state_d = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SLOW: begin
        cmd_o.op = OP_SLOW;
        sel_d    = SEL_DXX;
        state_d  = ST_MUL;
      end
      ST_REACH: begin
        cmd_o.op = OP_REACH;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        if (stat_i.stuck_now) begin
          sel_d   = SEL_BDC;
          state_d = ST_MUL;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_TX: begin
        cmd_o.op = OP_TX;
        sel_d    = SEL_BDS;
        state_d  = ST_MUL;
      end
      ST_TY: begin
        cmd_o.op = OP_TY;
        state_d  = ST_STUCK;
      end
      ST_STUCK: begin
        cmd_o.op = OP_STUCK;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_QYY;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ----- hw/rtl/sdr_dp.sv -----
module sdr_dp import sdr_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int TICK_BITS    = DEF_TICK_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdr_cmd_t              cmd_i,
  output sdr_stat_t             stat_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [1:0]            s_axis_tuser_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]            m_axis_tuser_o
);

  localparam int CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [HEAD_W-1:0] sat14(input logic signed [CU_W:0] v);
    logic signed [CU_W:0] r;
    r = (v + 35'sd32768) >>> 16;
    if (r > 35'sd16384) begin
      return ONE_Q14;
    end else if (r < -35'sd16384) begin
      return -ONE_Q14;
    end
    return r[HEAD_W-1:0];
  endfunction

  logic [CFG_N-1:0][CFG_W-1:0] cfg_q;
  logic [1:0]                  in_cmd_q;
  logic [IN_DATA_W-1:0]        in_data_q;

  logic signed [POS_W-1:0]  pos_q [3];
  logic signed [POS_W-1:0]  goal_q [3];
  logic signed [VEL_W-1:0]  vel_q [3];
  logic signed [POS_W-1:0]  t_q [3];
  logic signed [HEAD_W-1:0] hc_q, hs_q;
  logic                     odom_seen_q, goal_armed_q, slow_timing_q, rec_seen_q;
  logic                     slow_q, stuck_q, deg_q;
  logic [TICK_BITS-1:0]     tick_q, goal_stamp_q, slow_stamp_q, rec_stamp_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, ta_q;
  logic signed [CX_W-1:0]   cx_q, cy_q;
  logic signed [CU_W-1:0]   ux_q, uy_q;
  logic [CntW-1:0]          cnt_q;
  logic                     out_valid_q, out_stuck_q;
  logic [OUT_DATA_W-1:0]    out_data_q;

  logic signed [POS_W-1:0]  in_pos [3];
  logic signed [VEL_W-1:0]  in_vel [3];
  logic signed [QUAT_W-1:0] qx, qy, qz, qw;
  logic signed [POS_W:0]    dx, dy, dz;
  logic signed [MOP_W-1:0]  ma, mb;
  logic signed [CX_W-1:0]   ya, yb, xs, ys;
  logic signed [CU_W-1:0]   uxs, uys;
  logic signed [25:0]       bk;
  logic [TICK_BITS-1:0]     age_goal, age_slow, age_rec;
  logic                     cooling, elig;

  assign in_pos[0] = in_data_q[23:0];
  assign in_pos[1] = in_data_q[47:24];
  assign in_pos[2] = in_data_q[71:48];
  assign in_vel[0] = in_data_q[87:72];
  assign in_vel[1] = in_data_q[103:88];
  assign in_vel[2] = in_data_q[119:104];
  assign qx        = in_data_q[135:120];
  assign qy        = in_data_q[151:136];
  assign qz        = in_data_q[167:152];
  assign qw        = in_data_q[183:168];

  assign dx = 25'(pos_q[0]) - 25'(goal_q[0]);
  assign dy = 25'(pos_q[1]) - 25'(goal_q[1]);
  assign dz = 25'(pos_q[2]) - 25'(goal_q[2]);

  always_comb begin
    unique case (cmd_i.sel)
      SEL_QYY: begin ma = 26'(qy); mb = 26'(qy); end
      SEL_QZZ: begin ma = 26'(qz); mb = 26'(qz); end
      SEL_QWZ: begin ma = 26'(qw); mb = 26'(qz); end
      SEL_QXY: begin ma = 26'(qx); mb = 26'(qy); end
      SEL_VXX: begin ma = 26'(vel_q[0]); mb = 26'(vel_q[0]); end
      SEL_VYY: begin ma = 26'(vel_q[1]); mb = 26'(vel_q[1]); end
      SEL_VZZ: begin ma = 26'(vel_q[2]); mb = 26'(vel_q[2]); end
      SEL_THR: begin
        ma = 26'({1'b0, cfg_q[CFG_SPEED_THR]});
        mb = 26'({1'b0, cfg_q[CFG_SPEED_THR]});
      end
      SEL_DXX: begin ma = 26'(dx); mb = 26'(dx); end
      SEL_DYY: begin ma = 26'(dy); mb = 26'(dy); end
      SEL_DZZ: begin ma = 26'(dz); mb = 26'(dz); end
      SEL_RR: begin
        ma = 26'({1'b0, cfg_q[CFG_REACH]});
        mb = 26'({1'b0, cfg_q[CFG_REACH]});
      end
      SEL_BDC: begin ma = 26'({1'b0, cfg_q[CFG_BACKOFF]}); mb = 26'(hc_q); end
      SEL_BDS: begin ma = 26'({1'b0, cfg_q[CFG_BACKOFF]}); mb = 26'(hs_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign ya  = ONE_Q28 - (CX_W'(ta_q) <<< 1);
  assign yb  = CX_W'(acc_q) <<< 1;
  assign xs  = cx_q >>> cnt_q;
  assign ys  = cy_q >>> cnt_q;
  assign uxs = ux_q >>> cnt_q;
  assign uys = uy_q >>> cnt_q;
  assign bk  = 26'((PROD_W'(prod_q) + 52'sd8192) >>> 14);

  assign age_goal = tick_q - goal_stamp_q;
  assign age_slow = tick_q - slow_stamp_q;
  assign age_rec  = tick_q - rec_stamp_q;
  assign cooling  = rec_seen_q && (age_rec < TICK_BITS'(cfg_q[CFG_COOLDOWN]));
  assign elig     = goal_armed_q && (age_goal >= TICK_BITS'(cfg_q[CFG_SETTLE])) &&
                    slow_q && !cooling;

  assign stat_o.command     = in_cmd_q;
  assign stat_o.odom_seen   = odom_seen_q;
  assign stat_o.cordic_last = (cnt_q == CntW'(CORDIC_STEPS - 1));
  assign stat_o.stuck_now   = elig && slow_timing_q &&
                              (age_slow > TICK_BITS'(cfg_q[CFG_STUCK]));
  assign stat_o.out_free    = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_stuck_q, out_stuck_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (cmd_i.op == OP_MUL) begin
      prod_q <= ma * mb;
    end
    if (cmd_i.op == OP_MAC) begin
      acc_q <= (cmd_i.clr ? '0 : acc_q) + ACC_W'(prod_q);
    end
    if (cmd_i.op == OP_SAVE_A) begin
      ta_q <= acc_q;
    end
    if (cmd_i.op == OP_SLOW) begin
      slow_q <= ACC_W'(acc_q) < ACC_W'(prod_q);
    end
    if (cmd_i.op == OP_CINIT) begin
      cnt_q <= '0;
      deg_q <= (ya == '0) && (yb == '0);
      if (ya < 0) begin
        if (yb >= 0) begin
          cx_q <= yb; cy_q <= -ya; ux_q <= '0; uy_q <= CORDIC_GAIN_Q30;
        end else begin
          cx_q <= -yb; cy_q <= ya; ux_q <= '0; uy_q <= -CORDIC_GAIN_Q30;
        end
      end else begin
        cx_q <= ya; cy_q <= yb; ux_q <= CORDIC_GAIN_Q30; uy_q <= '0;
      end
    end
    if (cmd_i.op == OP_CSTEP) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cy_q >= 0) begin
        cx_q <= cx_q + ys; cy_q <= cy_q - xs; ux_q <= ux_q - uys; uy_q <= uy_q + uxs;
      end else begin
        cx_q <= cx_q - ys; cy_q <= cy_q + xs; ux_q <= ux_q + uys; uy_q <= uy_q - uxs;
      end
    end
    if (cmd_i.op == OP_DECIDE) begin
      stuck_q <= stat_o.stuck_now;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= '0;
      end
    end
    if (cmd_i.op == OP_TX) begin
      t_q[0] <= sat24(26'(pos_q[0]) - bk);
    end
    if (cmd_i.op == OP_TY) begin
      t_q[1] <= sat24(26'(pos_q[1]) - bk);
    end
    if (cmd_i.op == OP_STUCK) begin
      t_q[2] <= sat24(26'(pos_q[2]) + 26'({1'b0, cfg_q[CFG_CLIMB]}));
    end
    if (cmd_i.op == OP_EMIT) begin
      out_stuck_q <= stuck_q;
      out_data_q  <= {t_q[2], t_q[1], t_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= CFG_RESET;
      in_cmd_q      <= CMD_ODOM;
      odom_seen_q   <= 1'b0;
      goal_armed_q  <= 1'b0;
      slow_timing_q <= 1'b0;
      rec_seen_q    <= 1'b0;
      tick_q        <= '0;
      goal_stamp_q  <= '0;
      slow_stamp_q  <= '0;
      rec_stamp_q   <= '0;
      hc_q          <= '0;
      hs_q          <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        goal_q[i] <= '0;
        vel_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q[cfg_addr_i] <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        in_cmd_q <= s_axis_tuser_i;
      end
      if (out_valid_q && m_axis_tready_i && (cmd_i.op != OP_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_CFIN: begin
          odom_seen_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= in_pos[i];
            vel_q[i] <= in_vel[i];
          end
          if (deg_q) begin
            hc_q <= ONE_Q14;
            hs_q <= '0;
          end else begin
            hc_q <= sat14((CU_W + 1)'(ux_q));
            hs_q <= sat14((CU_W + 1)'(uy_q));
          end
        end
        OP_GOAL: begin
          for (int i = 0; i < 3; i++) begin
            goal_q[i] <= in_pos[i];
          end
          goal_armed_q <= 1'b1;
          goal_stamp_q <= tick_q;
        end
        OP_TICK: tick_q <= tick_q + TICK_BITS'(1);
        OP_SLOW: begin
          if (!(ACC_W'(acc_q) < ACC_W'(prod_q))) begin
            slow_timing_q <= 1'b0;
          end
        end
        OP_REACH: begin
          if (goal_armed_q && ((acc_q < ACC_W'(prod_q)) ||
              (age_goal > TICK_BITS'(cfg_q[CFG_TIMEOUT])))) begin
            goal_armed_q  <= 1'b0;
            slow_timing_q <= 1'b0;
          end
        end
        OP_DECIDE: begin
          if (elig && !slow_timing_q) begin
            slow_timing_q <= 1'b1;
            slow_stamp_q  <= tick_q;
          end
        end
        OP_STUCK: begin
          goal_q[0]     <= t_q[0];
          goal_q[1]     <= t_q[1];
          goal_q[2]     <= sat24(26'(pos_q[2]) + 26'({1'b0, cfg_q[CFG_CLIMB]}));
          goal_armed_q  <= 1'b1;
          goal_stamp_q  <= tick_q;
          rec_seen_q    <= 1'b1;
          rec_stamp_q   <= tick_q;
          slow_timing_q <= 1'b1;
          slow_stamp_q  <= tick_q;
        end
        OP_EMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sdr_chk.sv -----
module sdr_chk import sdr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]            m_axis_tuser_o
);

  // A target is carried exactly when stuck is flagged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == m_axis_tuser_o[1]))
    else $error("stuck flag and target valid disagree");

  // A word without a target carries a zero target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[1]) |-> (m_axis_tdata_o == '0))
    else $error("target fields not zero without a target");

  // Input words are taken one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output word changed");

endmodule

bind stuck_detect_recovery_goal_core sdr_chk u_sdr_chk (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tuser_o
);

// ----- verif/tb_stuck_detect_recovery_goal_core.sv -----
`timescale 1ns / 1ps

module tb_stuck_detect_recovery_goal_core;
  import sdr_pkg::*;

  localparam int GAP_MAX        = 11;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint S24_HI     = 64'sd8388607;
  localparam longint S24_LO     = -64'sd8388608;

  typedef struct packed {
    logic              drain;
    logic [1:0]        cmd;
    logic signed [15:0] qw, qz, qy, qx, vz, vy, vx;
    logic signed [23:0] pz, py, px;
  } word_t;

  typedef struct packed {
    logic        stuck;
    logic        tvalid;
    logic [23:0] tz, ty, tx;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic [1:0]            s_user = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [1:0]            m_user;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  stuck_detect_recovery_goal_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  word_t   word_q[$];
  result_t target_q[$];
  int      errors = 0;
  int      n_words = 0;
  int      n_results = 0;
  int      n_recoveries = 0;
  int      n_settings = 0;
  bit      idle_en = 1'b1;

  // Predicted block state.
  longint      cfg_m[CFG_N];
  longint      pos_m[3];
  longint      vel_m[3];
  longint      goal_m[3];
  longint      head_cos, head_sin;
  bit          odom_seen, goal_armed, slow_timing, rec_seen;
  logic [31:0] tick_cnt, goal_stamp, slow_stamp, rec_stamp;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint age_of(logic [31:0] stamp);
    logic [31:0] d;
    d = tick_cnt - stamp;
    return longint'({32'b0, d});
  endfunction

  function automatic void solve_heading(longint qx, longint qy, longint qz, longint qw);
    longint a, b, x, y, ux, uy, xs, ys, uxs, uys;
    a = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
    b = 2 * (qw * qz + qx * qy);
    if (a == 0 && b == 0) begin
      head_cos = 16384;
      head_sin = 0;
      return;
    end
    if (a < 0) begin
      if (b >= 0) begin
        x = b; y = -a; ux = 0; uy = longint'(CORDIC_GAIN_Q30);
      end else begin
        x = -b; y = a; ux = 0; uy = -longint'(CORDIC_GAIN_Q30);
      end
    end else begin
      x = a; y = b; ux = longint'(CORDIC_GAIN_Q30); uy = 0;
    end
    for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
      xs = x >>> i; ys = y >>> i; uxs = ux >>> i; uys = uy >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ux -= uys; uy += uxs;
      end else begin
        x -= ys; y += xs; ux += uys; uy -= uxs;
      end
    end
    head_cos = clampv((ux + 32768) >>> 16, -16384, 16384);
    head_sin = clampv((uy + 32768) >>> 16, -16384, 16384);
  endfunction

  function automatic void reset_model();
    cfg_m = '{120, 25, 1200, 500, 80, 1500, 300, 20};
    pos_m = '{0, 0, 0}; vel_m = '{0, 0, 0}; goal_m = '{0, 0, 0};
    head_cos = 0; head_sin = 0;
    odom_seen = 0; goal_armed = 0; slow_timing = 0; rec_seen = 0;
    tick_cnt = '0; goal_stamp = '0; slow_stamp = '0; rec_stamp = '0;
  endfunction

  function automatic void track_word(word_t w);
    longint sp2, d2, dd, bd;
    bit slow, cooling;
    result_t r;
    r = '0;
    case (w.cmd)
      CMD_ODOM: begin
        pos_m[0] = w.px; pos_m[1] = w.py; pos_m[2] = w.pz;
        vel_m[0] = w.vx; vel_m[1] = w.vy; vel_m[2] = w.vz;
        solve_heading(w.qx, w.qy, w.qz, w.qw);
        odom_seen = 1;
      end
      CMD_GOAL: begin
        goal_m[0] = w.px; goal_m[1] = w.py; goal_m[2] = w.pz;
        goal_armed = 1;
        goal_stamp = tick_cnt;
      end
      CMD_TICK: begin
        tick_cnt = tick_cnt + 1;
        if (odom_seen) begin
          sp2 = vel_m[0] * vel_m[0] + vel_m[1] * vel_m[1] + vel_m[2] * vel_m[2];
          slow = sp2 < cfg_m[0] * cfg_m[0];
          if (!slow) slow_timing = 0;
          if (goal_armed) begin
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
              dd = pos_m[i] - goal_m[i];
              d2 += dd * dd;
            end
            if (d2 < cfg_m[5] * cfg_m[5] || age_of(goal_stamp) > cfg_m[6]) begin
              goal_armed = 0;
              slow_timing = 0;
            end
          end
          if (goal_armed && age_of(goal_stamp) >= cfg_m[7]) begin
            cooling = rec_seen && age_of(rec_stamp) < cfg_m[4];
            if (slow && !cooling) begin
              if (!slow_timing) begin
                slow_timing = 1;
                slow_stamp = tick_cnt;
              end
              if (age_of(slow_stamp) > cfg_m[1]) begin
                bd = cfg_m[2];
                goal_m[0] = clampv(pos_m[0] - ((bd * head_cos + 8192) >>> 14), S24_LO, S24_HI);
                goal_m[1] = clampv(pos_m[1] - ((bd * head_sin + 8192) >>> 14), S24_LO, S24_HI);
                goal_m[2] = clampv(pos_m[2] + cfg_m[3], S24_LO, S24_HI);
                r.stuck = 1'b1;
                r.tvalid = 1'b1;
                r.tx = goal_m[0][23:0];
                r.ty = goal_m[1][23:0];
                r.tz = goal_m[2][23:0];
                goal_armed = 1;
                goal_stamp = tick_cnt;
                rec_seen = 1;
                rec_stamp = tick_cnt;
                slow_timing = 1;
                slow_stamp = tick_cnt;
              end
            end
          end
          target_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver.
  word_t cur_w = '0;
  int    send_gap = 0;
  logic  send_nv;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      send_nv = s_valid;
      if (s_valid && s_ready) begin
        track_word(cur_w);
        n_words++;
        send_nv = 1'b0;
        send_gap = idle_en ? $urandom_range(GAP_MAX, 0) : 0;
      end
      if (!send_nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() > 0 && !(word_q[0].drain && target_q.size() > 0)) begin
          cur_w = word_q.pop_front();
          send_nv = 1'b1;
        end
      end
      s_valid <= send_nv;
      s_data <= cur_w[IN_DATA_W-1:0];
      s_user <= cur_w.cmd;
    end
  end

  // Monitor.
  int      recv_gap = 0;
  logic    recv_nr;
  result_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      recv_nr = m_ready;
      if (m_valid && m_ready) begin
        got.stuck = m_user[0];
        got.tvalid = m_user[1];
        got.tx = m_data[23:0];
        got.ty = m_data[47:24];
        got.tz = m_data[71:48];
        n_results++;
        if (target_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          want = target_q.pop_front();
          if (got.stuck && want.stuck) n_recoveries++;
          if (got.stuck !== want.stuck) begin
            $display("%0t: stuck_flag expected %0d actual %0d", $time, want.stuck, got.stuck);
            errors++;
          end
          if (got.tvalid !== want.tvalid) begin
            $display("%0t: target_valid expected %0d actual %0d", $time, want.tvalid,
                     got.tvalid);
            errors++;
          end
          if (got.tx !== want.tx) begin
            $display("%0t: target_x expected %h actual %h", $time, want.tx, got.tx);
            errors++;
          end
          if (got.ty !== want.ty) begin
            $display("%0t: target_y expected %h actual %h", $time, want.ty, got.ty);
            errors++;
          end
          if (got.tz !== want.tz) begin
            $display("%0t: target_z expected %h actual %h", $time, want.tz, got.tz);
            errors++;
          end
        end
        recv_nr = 1'b0;
        recv_gap = idle_en ? $urandom_range(GAP_MAX, 0) : 0;
      end
      if (!recv_nr) begin
        if (recv_gap > 0) recv_gap--;
        else recv_nr = 1'b1;
      end
      m_ready <= recv_nr;
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("stuck_detect_recovery_goal_core verification failed");
        $finish;
      end
    end
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic word_t mk(logic [1:0] cmd, int px, int py, int pz, int vx, int vy,
                               int vz, int qx, int qy, int qz, int qw);
    word_t w;
    w = '0;
    w.cmd = cmd;
    w.px = 24'(px); w.py = 24'(py); w.pz = 24'(pz);
    w.vx = 16'(vx); w.vy = 16'(vy); w.vz = 16'(vz);
    w.qx = 16'(qx); w.qy = 16'(qy); w.qz = 16'(qz); w.qw = 16'(qw);
    return w;
  endfunction

  function automatic word_t rand_word(logic [1:0] cmd);
    word_t w;
    w = mk(cmd, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom());
    return w;
  endfunction

  function automatic word_t odom_word(int px, int py, int pz, bit fast);
    word_t w;
    w = rand_word(CMD_ODOM);
    w.px = 24'(px); w.py = 24'(py); w.pz = 24'(pz);
    if (!fast) begin
      w.vx = 16'(rnd(-60, 60)); w.vy = 16'(rnd(-60, 60)); w.vz = 16'(rnd(-60, 60));
    end else if ($urandom_range(1, 0) == 0) begin
      w.vx = 16'(rnd(-3000, 3000)); w.vy = 16'(rnd(-3000, 3000));
      w.vz = 16'(rnd(-3000, 3000));
    end
    if ($urandom_range(3, 0) != 0) begin
      w.qx = 16'(rnd(-16384, 16384)); w.qy = 16'(rnd(-16384, 16384));
      w.qz = 16'(rnd(-16384, 16384)); w.qw = 16'(rnd(-16384, 16384));
    end
    return w;
  endfunction

  function automatic int far_offset();
    int m;
    m = ($urandom_range(5, 0) == 0) ? rnd(-500, 500) : rnd(3000, 200000);
    return $urandom_range(1, 0) ? m : -m;
  endfunction

  // Random part: mostly track-and-stall episodes, with some noise words.
  task automatic fill_random(int count);
    int start, bx, by, bz, ticks;
    start = word_q.size();
    while (word_q.size() - start < count) begin
      if ($urandom_range(9, 0) == 0) begin
        word_q.push_back(rand_word(2'($urandom_range(3, 0))));
        continue;
      end
      if ($urandom_range(7, 0) == 0) begin
        bx = $signed($urandom() << 8) >>> 8;
        by = $signed($urandom() << 8) >>> 8;
        bz = $signed($urandom() << 8) >>> 8;
      end else begin
        bx = rnd(-50000, 50000); by = rnd(-50000, 50000); bz = rnd(-50000, 50000);
      end
      word_q.push_back(odom_word(bx, by, bz, 1'b0));
      word_q.push_back(mk(CMD_GOAL, bx + far_offset(), by + far_offset(), bz + far_offset(),
                          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom()));
      ticks = rnd(1, 45);
      repeat (ticks) begin
        word_q.push_back(rand_word(CMD_TICK));
        case ($urandom_range(59, 0))
          0, 1, 2, 3, 4, 5, 6:
            word_q.push_back(odom_word(bx + rnd(-300, 300), by + rnd(-300, 300),
                                       bz + rnd(-300, 300), 1'b0));
          7, 8: word_q.push_back(odom_word(bx, by, bz, 1'b1));
          9: word_q.push_back(rand_word(2'd3));
          10: word_q.push_back(mk(CMD_GOAL, bx + far_offset(), by + far_offset(),
                                  bz + far_offset(), 0, 0, 0, 0, 0, 0, 0));
          default: ;
        endcase
      end
    end
  endtask

  task automatic write_regs(longint vals[CFG_N]);
    for (int i = 0; i < CFG_N; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_addr <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i][CFG_W-1:0];
      cfg_m[i] = vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (word_q.size() > 0 || s_valid || target_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_directed();
    word_t w;
    word_q.push_back(rand_word(CMD_TICK));
    word_q.push_back(rand_word(2'd3));
    word_q.push_back(mk(CMD_GOAL, 8388607, -8388608, -8388608, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_ODOM, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0, 0, 16384));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_TICK, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    word_q.push_back(mk(CMD_ODOM, 0, 0, 0, 32767, -32768, 32767, 0, 8192, 8192, 0));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_ODOM, 8388607, -8388608, -8388608, -32768, 32767, -32768,
                        -32768, 32767, -32768, 32767));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_ODOM, 8388607, 0, 0, 0, 0, 0, 0, 0, 16384, 0));
    word_q.push_back(mk(CMD_GOAL, -8388608, 8388607, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_ODOM, 1000, 2000, 3000, 5, -5, 0, -16384, -16384, -16384,
                        -16384));
    word_q.push_back(mk(CMD_GOAL, 1000, 2000, 3000, 0, 0, 0, 0, 0, 0, 0));
    word_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    w = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    w.drain = 1'b1;
    word_q.push_back(w);
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_regs('{65535, 0, 65535, 65535, 0, 1000, 65535, 0});
    add_directed();
    wait_drained();

    write_regs('{120, 25, 1200, 500, 80, 1500, 300, 20});
    fill_random(230);
    wait_drained();

    write_regs('{2000, 3, 3000, 800, 5, 2000, 200, 2});
    fill_random(110);
    begin
      word_t w;
      w = rand_word(CMD_TICK);
      w.drain = 1'b1;
      word_q.push_back(w);
    end
    fill_random(110);
    wait_drained();

    idle_en = 1'b0;
    write_regs('{0, 0, 0, 0, 0, 0, 0, 0});
    fill_random(200);
    wait_drained();
    idle_en = 1'b1;

    write_regs('{65535, 1, 65535, 65535, 65535, 65535, 65535, 1});
    fill_random(220);
    wait_drained();

    write_regs('{500, 6, 1500, 300, 10, 800, 60, 3});
    fill_random(230);
    wait_drained();

    if (target_q.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, target_q.size());
      errors++;
    end
    $display("Sent %0d words under %0d register settings; checked %0d results.",
             n_words, n_settings, n_results);
    $display("Recovery targets seen: %0d.", n_recoveries);
    if (errors == 0) begin
      $display("stuck_detect_recovery_goal_core verification clean");
    end else begin
      $display("stuck_detect_recovery_goal_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_ctrl.sv
hw/rtl/sdr_dp.sv
hw/rtl/stuck_detect_recovery_goal_core.sv
hw/rtl/sdr_chk.sv
verif/tb_stuck_detect_recovery_goal_core.sv
